// ----- hw/rtl/graph_neighbor_reservoir_sampler_macros.svh -----
// Assertion macros for the neighbor sampler RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef GRAPH_NEIGHBOR_RESERVOIR_SAMPLER_MACROS_SVH
`define GRAPH_NEIGHBOR_RESERVOIR_SAMPLER_MACROS_SVH
`ifndef SYNTH
`define GNRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GNRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GNRS_ASSERT(lbl, prop, msg)
`define GNRS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/gnrs_pkg.sv -----
// Shared constants, codes, types and functions of the neighbor sampler.
// No dependencies.
package gnrs_pkg;

  localparam int MAX_NODES  = 65536;
  localparam int NODE_W     = 16;
  localparam int ROW_DEPTH  = MAX_NODES + 1;
  localparam int ROW_AW     = 17;
  localparam int MAX_EDGES  = 1048576;
  localparam int EDGE_AW    = 20;
  localparam int PTR_W      = 21;
  localparam int MAX_FANOUT = 16;
  localparam int FO_W       = 5;
  localparam int SLOT_W     = 4;
  localparam int RNG_W      = 32;
  localparam int CNT_W      = 5;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [FO_W-1:0]  FANOUT_RST = FO_W'(10);
  localparam logic [RNG_W-1:0] SEED_RST   = RNG_W'(1);

  localparam logic [REQ_W-1:0] REQ_ROW    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NBR    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FANOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ROW1 = 8'b0000_0010,
    S_ROW2 = 8'b0000_0100,
    S_NRD  = 8'b0000_1000,
    S_NUSE = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_EMIT = 8'b0100_0000,
    S_ONE  = 8'b1000_0000
  } state_t;

  function automatic logic [RNG_W-1:0] xorshift(input logic [RNG_W-1:0] x);
    logic [RNG_W-1:0] a;
    logic [RNG_W-1:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    return (p > PTR_W'(MAX_EDGES)) ? PTR_W'(MAX_EDGES) : p;
  endfunction

endpackage

// ----- hw/rtl/gnrs_ifs.sv -----
// Channel interfaces of the neighbor sampler: request, edge result, config.
// Depends on gnrs_pkg.
interface gnrs_req_if;
  logic                        valid;
  logic                        ready;
  logic [gnrs_pkg::REQ_W-1:0]  req_type;
  logic [gnrs_pkg::EDGE_AW-1:0] index;
  logic [gnrs_pkg::PTR_W-1:0]  value;
  modport source (output valid, req_type, index, value, input ready);
  modport sink (input valid, req_type, index, value, output ready);
endinterface

interface gnrs_edge_if;
  logic                        valid;
  logic                        ready;
  logic [gnrs_pkg::NODE_W-1:0] src_node;
  logic [gnrs_pkg::NODE_W-1:0] dst_node;
  logic                        edge_valid;
  logic                        short_list;
  logic                        last;
  modport source (output valid, src_node, dst_node, edge_valid, short_list, last,
                  input ready);
  modport sink (input valid, src_node, dst_node, edge_valid, short_list, last,
                output ready);
endinterface

interface gnrs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gnrs_pkg::CFG_IDX_W-1:0] index;
  logic [gnrs_pkg::RNG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/graph_neighbor_reservoir_sampler.sv -----
// Graph neighbor sampler: CSR stores, reservoir sampling, edge output register.
// Depends on gnrs_pkg, gnrs_ifs.sv and graph_neighbor_reservoir_sampler_macros.svh.
//
// Channels: req (load a row pointer, load a neighbor, or sample a node), edges
// (one word per emitted edge, last marks the node's final word), cfg (fanout at
// index 0, seed at index 1; always ready; the user writes it only while idle,
// as the block does not enforce this). A sample reads the row pointer store
// twice, then walks the neighbor list: when the list fits in fanout each
// neighbor is read and emitted; for a longer list the first neighbors seed the
// reservoir slots and each later neighbor draws a slot with the 32-step
// remainder unit; then the slots are emitted, one per cycle unless stalled.
// One item is in work at a time; req is ready only between items. Results pass
// through one output register, so the next item is taken while the final word
// still waits. A stalled receiver holds the walk at the next emit.
// Reset (synchronous, rst high) sets fanout to 10 and the random state to 1;
// the stores are not cleared and must be loaded before sampling.
module graph_neighbor_reservoir_sampler (
  input  logic clk,
  input  logic rst,
  gnrs_req_if.sink    req,
  gnrs_edge_if.source edges,
  gnrs_cfg_if.sink    cfg
);

  `include "graph_neighbor_reservoir_sampler_macros.svh"

  logic [gnrs_pkg::PTR_W-1:0]  row_mem [gnrs_pkg::ROW_DEPTH];
  logic [gnrs_pkg::NODE_W-1:0] nbr_mem [gnrs_pkg::MAX_EDGES];
  logic [gnrs_pkg::NODE_W-1:0] rsv [gnrs_pkg::MAX_FANOUT];

  gnrs_pkg::state_t st;
  logic [gnrs_pkg::FO_W-1:0]    fanout;
  logic [gnrs_pkg::RNG_W-1:0]   rng_state;
  logic [gnrs_pkg::PTR_W-1:0]   node;
  logic [gnrs_pkg::FO_W-1:0]    fo;
  logic [gnrs_pkg::PTR_W-1:0]   off;
  logic [gnrs_pkg::PTR_W-1:0]   len;
  logic [gnrs_pkg::PTR_W-1:0]   j;
  logic [gnrs_pkg::SLOT_W-1:0]  e;
  logic                         short_mode;
  logic [gnrs_pkg::PTR_W-1:0]   row_q;
  logic [gnrs_pkg::NODE_W-1:0]  nb_q;
  logic [gnrs_pkg::RNG_W-1:0]   dvd;
  logic [gnrs_pkg::PTR_W-1:0]   rem;
  logic [gnrs_pkg::PTR_W-1:0]   dsr;
  logic [gnrs_pkg::CNT_W-1:0]   cnt;
  logic                         out_v;

  logic                        req_acc;
  logic                        can_push;
  logic                        push;
  logic [gnrs_pkg::NODE_W-1:0] p_dst;
  logic                        p_valid;
  logic                        p_short;
  logic                        p_last;
  logic [gnrs_pkg::ROW_AW-1:0] row_ra;
  logic [gnrs_pkg::PTR_W-1:0]  end_ptr;
  logic [gnrs_pkg::PTR_W-1:0]  fo_w;
  logic [gnrs_pkg::PTR_W:0]    div_t;
  logic [gnrs_pkg::PTR_W-1:0]  rem_new;
  logic                        rsv_we;
  logic [gnrs_pkg::SLOT_W-1:0] rsv_wa;
  logic [gnrs_pkg::FO_W-1:0]   fo_in;

  assign req.ready = (st == gnrs_pkg::S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign can_push  = !out_v || edges.ready;
  assign fo_w      = gnrs_pkg::PTR_W'(fo);
  assign end_ptr   = gnrs_pkg::clamp_ptr(row_q);

  always_comb begin
    if (fanout == '0) begin
      fo_in = gnrs_pkg::FO_W'(1);
    end else if (fanout > gnrs_pkg::FO_W'(gnrs_pkg::MAX_FANOUT)) begin
      fo_in = gnrs_pkg::FO_W'(gnrs_pkg::MAX_FANOUT);
    end else begin
      fo_in = fanout;
    end
  end

  // restoring remainder step: one dividend bit per cycle
  assign div_t   = {rem, dvd[gnrs_pkg::RNG_W-1]};
  assign rem_new = (div_t >= {1'b0, dsr}) ? gnrs_pkg::PTR_W'(div_t - {1'b0, dsr})
                                          : div_t[gnrs_pkg::PTR_W-1:0];

  always_comb begin
    row_ra = req.value[gnrs_pkg::ROW_AW-1:0];
    if (st == gnrs_pkg::S_ROW1) begin
      row_ra = node[gnrs_pkg::ROW_AW-1:0] + gnrs_pkg::ROW_AW'(1);
    end
  end

  always_comb begin
    push    = 1'b0;
    p_dst   = nb_q;
    p_valid = 1'b1;
    p_short = (len < fo_w);
    p_last  = (j + gnrs_pkg::PTR_W'(1) == len);
    rsv_we  = 1'b0;
    rsv_wa  = j[gnrs_pkg::SLOT_W-1:0];
    unique case (st)
      gnrs_pkg::S_NUSE: begin
        if (short_mode) begin
          push = can_push;
        end else if (j < fo_w) begin
          rsv_we = 1'b1;
        end
      end
      gnrs_pkg::S_DIV: begin
        if (cnt == '1 && rem_new < fo_w) begin
          rsv_we = 1'b1;
          rsv_wa = rem_new[gnrs_pkg::SLOT_W-1:0];
        end
      end
      gnrs_pkg::S_EMIT: begin
        push    = can_push;
        p_dst   = rsv[e];
        p_short = 1'b0;
        p_last  = (gnrs_pkg::FO_W'(e) + gnrs_pkg::FO_W'(1) == fo);
      end
      gnrs_pkg::S_ONE: begin
        push    = can_push;
        p_dst   = '0;
        p_valid = 1'b0;
        p_short = 1'b1;
        p_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // stores: write on load words, read data registered
  always_ff @(posedge clk) begin
    if (req_acc && req.req_type == gnrs_pkg::REQ_ROW &&
        req.index < gnrs_pkg::EDGE_AW'(gnrs_pkg::ROW_DEPTH)) begin
      row_mem[req.index[gnrs_pkg::ROW_AW-1:0]] <= req.value;
    end
    row_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (req_acc && req.req_type == gnrs_pkg::REQ_NBR) begin
      nbr_mem[req.index] <= req.value[gnrs_pkg::NODE_W-1:0];
    end
    if (st == gnrs_pkg::S_NRD) begin
      nb_q <= nbr_mem[off[gnrs_pkg::EDGE_AW-1:0] + j[gnrs_pkg::EDGE_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rsv_we) begin
      rsv[rsv_wa] <= nb_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= gnrs_pkg::S_IDLE;
      fanout    <= gnrs_pkg::FANOUT_RST;
      rng_state <= gnrs_pkg::SEED_RST;
      out_v     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          gnrs_pkg::CFG_FANOUT: fanout <= cfg.data[gnrs_pkg::FO_W-1:0];
          gnrs_pkg::CFG_SEED: rng_state <= (cfg.data == '0) ? gnrs_pkg::SEED_RST : cfg.data;
          default: begin
          end
        endcase
      end

      if (push) begin
        out_v <= 1'b1;
      end else if (edges.ready) begin
        out_v <= 1'b0;
      end

      unique case (st)
        gnrs_pkg::S_IDLE: begin
          if (req_acc && req.req_type == gnrs_pkg::REQ_SAMPLE) begin
            if (req.value >= gnrs_pkg::PTR_W'(gnrs_pkg::MAX_NODES)) begin
              st <= gnrs_pkg::S_ONE;
            end else begin
              st <= gnrs_pkg::S_ROW1;
            end
          end
        end
        gnrs_pkg::S_ROW1: st <= gnrs_pkg::S_ROW2;
        gnrs_pkg::S_ROW2: begin
          if (end_ptr > off) begin
            st <= gnrs_pkg::S_NRD;
          end else begin
            st <= gnrs_pkg::S_ONE;
          end
        end
        gnrs_pkg::S_NRD: st <= gnrs_pkg::S_NUSE;
        gnrs_pkg::S_NUSE: begin
          if (short_mode) begin
            if (can_push) begin
              st <= p_last ? gnrs_pkg::S_IDLE : gnrs_pkg::S_NRD;
            end
          end else if (j < fo_w) begin
            st <= gnrs_pkg::S_NRD;
          end else begin
            rng_state <= gnrs_pkg::xorshift(rng_state);
            st        <= gnrs_pkg::S_DIV;
          end
        end
        gnrs_pkg::S_DIV: begin
          if (cnt == '1) begin
            st <= p_last ? gnrs_pkg::S_EMIT : gnrs_pkg::S_NRD;
          end
        end
        gnrs_pkg::S_EMIT: begin
          if (can_push && p_last) begin
            st <= gnrs_pkg::S_IDLE;
          end
        end
        gnrs_pkg::S_ONE: begin
          if (can_push) begin
            st <= gnrs_pkg::S_IDLE;
          end
        end
        default: st <= gnrs_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (st)
      gnrs_pkg::S_IDLE: begin
        node <= req.value;
        fo   <= fo_in;
        len  <= '0;
        j    <= '0;
        e    <= '0;
      end
      gnrs_pkg::S_ROW1: off <= gnrs_pkg::clamp_ptr(row_q);
      gnrs_pkg::S_ROW2: begin
        len        <= end_ptr - off;
        short_mode <= (end_ptr - off) <= fo_w;
      end
      gnrs_pkg::S_NUSE: begin
        if (short_mode) begin
          if (can_push) begin
            j <= j + gnrs_pkg::PTR_W'(1);
          end
        end else if (j < fo_w) begin
          j <= j + gnrs_pkg::PTR_W'(1);
        end else begin
          dvd <= gnrs_pkg::xorshift(rng_state);
          rem <= '0;
          dsr <= j + gnrs_pkg::PTR_W'(1);
          cnt <= '0;
        end
      end
      gnrs_pkg::S_DIV: begin
        dvd <= dvd << 1;
        rem <= rem_new;
        cnt <= cnt + gnrs_pkg::CNT_W'(1);
        if (cnt == '1 && !p_last) begin
          j <= j + gnrs_pkg::PTR_W'(1);
        end
      end
      gnrs_pkg::S_EMIT: begin
        if (can_push) begin
          e <= e + gnrs_pkg::SLOT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      edges.src_node   <= node[gnrs_pkg::NODE_W-1:0];
      edges.dst_node   <= p_dst;
      edges.edge_valid <= p_valid;
      edges.short_list <= p_short;
      edges.last       <= p_last;
    end
  end

  assign edges.valid = out_v;

  `GNRS_ASSERT(a_push_room, push |-> (!out_v || edges.ready), "push into a full output register")
  `GNRS_ASSERT(a_rem_below, (st == gnrs_pkg::S_DIV) |-> (rem < dsr), "remainder not below divisor")
  `GNRS_ASSERT(a_rsv_slot, rsv_we |-> (gnrs_pkg::FO_W'(rsv_wa) < fo), "reservoir slot beyond fanout")
  `GNRS_ASSERT(a_rng_live, rng_state != '0, "random state stuck at zero")

endmodule
